// File: design/plf_pkg.sv
`default_nettype none

package plf_pkg;

  // defaults for the top level parameters
  localparam int COORD_BITS_DEF      = 12;
  localparam int RECIP_FRAC_BITS_DEF = 16;

  // register field widths
  localparam int LIGHT_BITS = 17;
  localparam int SCALE_BITS = 24;
  localparam int INV_BITS   = 32;
  localparam int CHAN_BITS  = 8;

  // position fraction bits (Q.4)
  localparam int POS_FRAC_BITS = 4;

  // offset is Q.20, anything at or above 2^32 saturates the square term
  localparam int OFF_KEEP_BITS = 32;
  localparam int SQ_SHIFT      = 16;

  // square term and sum, Q.24
  localparam int SUM_FRAC_BITS = 24;
  localparam int TERM_BITS     = 49;
  localparam int SUM_BITS      = 50;

  // falloff factor, wide enough for the zero-sum value 2^48
  localparam int R_BITS = 49;

  localparam logic [TERM_BITS-1:0] SQ_LIMIT = {1'b1, {(TERM_BITS-1){1'b0}}};
  localparam logic [R_BITS-1:0]    R_LIMIT  = {1'b1, {(R_BITS-1){1'b0}}};

  localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'd255;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_X   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_Y   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_LEVEL = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RED       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_GREEN     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLUE      = 3'd6;

  // reset values
  localparam logic [LIGHT_BITS-1:0] LIGHT_RST = '0;
  localparam logic [SCALE_BITS-1:0] SCALE_RST = 24'h01_0000;
  localparam logic [INV_BITS-1:0]   INV_RST   = 32'h0100_0000;
  localparam logic [CHAN_BITS-1:0]  CHAN_RST  = 8'd255;

  // output pixel, alpha in the lowest byte
  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic [CHAN_BITS-1:0] alpha;
  } pix_t;

endpackage

`default_nettype wire

// File: design/point_light_falloff_pixel.sv
// point light falloff, one pixel per word
//
// s_* channel: pixel coordinate in, one word per pixel (col, row).
// m_* channel: one pixel word out per input word (alpha, blue, green, red),
//   in the order the coordinates came in.
// cfg_*: register writes, taken at any edge with cfg_we high; write them
//   only while no pixel is in flight. index 7 is ignored.
//
// throughput: one pixel per cycle while the skid register is not full.
// the reciprocal is a restoring divider unrolled one quotient bit per pipeline
//   stage, which sets the pipeline depth.
//
// reset clears every valid bit and loads the registers with their defaults
// (light at the origin, unit scale and intensity, white light).
// when the receiver stalls the result is held on m_tdata; one more result
// goes into a skid register, and only once that is full does s_tready drop,
// freezing the whole pipeline in place.
`default_nettype none

module point_light_falloff_pixel #(
  parameter int COORD_BITS      = plf_pkg::COORD_BITS_DEF,
  parameter int RECIP_FRAC_BITS = plf_pkg::RECIP_FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // col, row
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // alpha_out, blue_out, green_out, red_out
  output logic [4*plf_pkg::CHAN_BITS-1:0]             m_tdata,
  input  wire logic                                   cfg_we,
  input  wire logic [plf_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [plf_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int LB  = plf_pkg::LIGHT_BITS;
  localparam int CB  = plf_pkg::CHAN_BITS;
  localparam int SB  = plf_pkg::SUM_BITS;
  localparam int RB  = plf_pkg::R_BITS;
  localparam int POS_BITS = COORD_BITS + plf_pkg::POS_FRAC_BITS;
  localparam int MAG_BITS = ((POS_BITS > LB - 1) ? POS_BITS : LB - 1) + 1;
  localparam int D_BITS   = MAG_BITS + 1;
  localparam int OFF_BITS = MAG_BITS + plf_pkg::SCALE_BITS;
  localparam int Q_BITS   = plf_pkg::SUM_FRAC_BITS + RECIP_FRAC_BITS + 1;
  localparam int NUM_BITS = (plf_pkg::SUM_FRAC_BITS + RECIP_FRAC_BITS + 2 > SB) ?
                            plf_pkg::SUM_FRAC_BITS + RECIP_FRAC_BITS + 2 : SB;
  localparam int PROD_BITS = CB + RB;
  localparam int V_BITS    = PROD_BITS - RECIP_FRAC_BITS;
  localparam int RI_BITS   = RB + 1 - RECIP_FRAC_BITS;

  localparam logic [NUM_BITS-1:0]  NUM_ONE =
    NUM_BITS'(1) << (plf_pkg::SUM_FRAC_BITS + RECIP_FRAC_BITS);
  localparam logic [PROD_BITS-1:0] HALF_P = PROD_BITS'(1) << (RECIP_FRAC_BITS - 1);
  localparam logic [RB:0]          HALF_R = (RB+1)'(1) << (RECIP_FRAC_BITS - 1);

  // configuration registers
  logic signed [LB-1:0]                   light_x;
  logic signed [LB-1:0]                   light_y;
  logic [plf_pkg::SCALE_BITS-1:0]         scale;
  logic [plf_pkg::INV_BITS-1:0]           inv_level;
  logic [CB-1:0]                          red;
  logic [CB-1:0]                          green;
  logic [CB-1:0]                          blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x   <= plf_pkg::LIGHT_RST;
      light_y   <= plf_pkg::LIGHT_RST;
      scale     <= plf_pkg::SCALE_RST;
      inv_level <= plf_pkg::INV_RST;
      red       <= plf_pkg::CHAN_RST;
      green     <= plf_pkg::CHAN_RST;
      blue      <= plf_pkg::CHAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plf_pkg::REG_LIGHT_X:   light_x   <= cfg_data[LB-1:0];
        plf_pkg::REG_LIGHT_Y:   light_y   <= cfg_data[LB-1:0];
        plf_pkg::REG_SCALE:     scale     <= cfg_data[plf_pkg::SCALE_BITS-1:0];
        plf_pkg::REG_INV_LEVEL: inv_level <= cfg_data[plf_pkg::INV_BITS-1:0];
        plf_pkg::REG_RED:       red       <= cfg_data[CB-1:0];
        plf_pkg::REG_GREEN:     green     <= cfg_data[CB-1:0];
        plf_pkg::REG_BLUE:      blue      <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: held only while the skid register is full
  logic skid_valid;
  logic out_valid;
  logic adv;
  assign adv      = !skid_valid;
  assign s_tready = adv;

  // stage 1: position offsets
  logic [COORD_BITS-1:0]    col;
  logic [COORD_BITS-1:0]    row;
  logic signed [D_BITS-1:0] dx;
  logic signed [D_BITS-1:0] dy;
  logic [MAG_BITS-1:0]      mag_x_next;
  logic [MAG_BITS-1:0]      mag_y_next;

  assign col = s_tdata[COORD_BITS-1:0];
  assign row = s_tdata[2*COORD_BITS-1:COORD_BITS];

  always_comb begin
    dx = D_BITS'(light_x) - $signed(D_BITS'({col, {plf_pkg::POS_FRAC_BITS{1'b0}}}));
    dy = D_BITS'(light_y) - $signed(D_BITS'({row, {plf_pkg::POS_FRAC_BITS{1'b0}}}));
    mag_x_next = dx[D_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
    mag_y_next = dy[D_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
  end

  logic [MAG_BITS-1:0] mag_x;
  logic [MAG_BITS-1:0] mag_y;

  // stage 2: scaled offsets, Q.20
  logic [OFF_BITS-1:0] off_x;
  logic [OFF_BITS-1:0] off_y;

  // stage 3: square terms, Q.24
  logic [plf_pkg::TERM_BITS-1:0] term_x;
  logic [plf_pkg::TERM_BITS-1:0] term_y;
  logic [plf_pkg::TERM_BITS-1:0] term_x_next;
  logic [plf_pkg::TERM_BITS-1:0] term_y_next;
  logic [2*plf_pkg::OFF_KEEP_BITS-1:0] sq_x;
  logic [2*plf_pkg::OFF_KEEP_BITS-1:0] sq_y;

  always_comb begin
    sq_x = (2*plf_pkg::OFF_KEEP_BITS)'(off_x[plf_pkg::OFF_KEEP_BITS-1:0]) *
           (2*plf_pkg::OFF_KEEP_BITS)'(off_x[plf_pkg::OFF_KEEP_BITS-1:0]);
    sq_y = (2*plf_pkg::OFF_KEEP_BITS)'(off_y[plf_pkg::OFF_KEEP_BITS-1:0]) *
           (2*plf_pkg::OFF_KEEP_BITS)'(off_y[plf_pkg::OFF_KEEP_BITS-1:0]);
    // far pixel: square term saturates
    term_x_next = (|off_x[OFF_BITS-1:plf_pkg::OFF_KEEP_BITS]) ? plf_pkg::SQ_LIMIT :
                  plf_pkg::TERM_BITS'(sq_x >> plf_pkg::SQ_SHIFT);
    term_y_next = (|off_y[OFF_BITS-1:plf_pkg::OFF_KEEP_BITS]) ? plf_pkg::SQ_LIMIT :
                  plf_pkg::TERM_BITS'(sq_y >> plf_pkg::SQ_SHIFT);
  end

  // stage 4: distance sum
  logic [SB-1:0] sum;

  // stage 5 and divider: remainder and shifting numerator/quotient word
  logic [NUM_BITS-1:0] num;
  assign num = NUM_ONE + NUM_BITS'(sum >> 1);

  logic [SB-1:0]     drem [0:Q_BITS];
  logic [Q_BITS-1:0] dnq  [0:Q_BITS];
  logic [SB-1:0]     dsum [0:Q_BITS];
  logic              dz   [0:Q_BITS];
  logic              dv   [0:Q_BITS];

  logic [SB:0]       rsh   [1:Q_BITS];
  logic              ge    [1:Q_BITS];
  logic [SB-1:0]     nrem  [1:Q_BITS];

  // one restoring step per stage
  always_comb begin
    for (int k = 1; k <= Q_BITS; k++) begin
      rsh[k]  = {drem[k-1], dnq[k-1][Q_BITS-1]};
      ge[k]   = rsh[k] >= (SB+1)'(dsum[k-1]);
      nrem[k] = ge[k] ? SB'(rsh[k] - (SB+1)'(dsum[k-1])) : SB'(rsh[k]);
    end
  end

  // tail: factor, products, clamp
  logic [RB-1:0]        r;
  logic [PROD_BITS-1:0] p_red;
  logic [PROD_BITS-1:0] p_green;
  logic [PROD_BITS-1:0] p_blue;
  logic [RB:0]          p_alpha;

  logic [V_BITS-1:0]    v_red;
  logic [V_BITS-1:0]    v_green;
  logic [V_BITS-1:0]    v_blue;
  logic [RI_BITS-1:0]   ri;
  plf_pkg::pix_t        pix_next;
  plf_pkg::pix_t        pix;

  always_comb begin
    v_red   = V_BITS'(p_red >> RECIP_FRAC_BITS);
    v_green = V_BITS'(p_green >> RECIP_FRAC_BITS);
    v_blue  = V_BITS'(p_blue >> RECIP_FRAC_BITS);
    ri      = RI_BITS'(p_alpha >> RECIP_FRAC_BITS);
    pix_next.red   = (|v_red[V_BITS-1:CB])   ? plf_pkg::CHAN_MAX : v_red[CB-1:0];
    pix_next.green = (|v_green[V_BITS-1:CB]) ? plf_pkg::CHAN_MAX : v_green[CB-1:0];
    pix_next.blue  = (|v_blue[V_BITS-1:CB])  ? plf_pkg::CHAN_MAX : v_blue[CB-1:0];
    // bright pixel: alpha bottoms out at zero
    pix_next.alpha = (ri >= RI_BITS'(plf_pkg::CHAN_MAX)) ? '0 :
                     CB'(RI_BITS'(plf_pkg::CHAN_MAX) - ri);
  end

  logic v1, v2, v3, v4, v6, v7, v8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      for (int k = 0; k <= Q_BITS; k++) begin
        dv[k] <= 1'b0;
      end
    end else if (adv) begin
      v1    <= s_tvalid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      dv[0] <= v4;
      for (int k = 1; k <= Q_BITS; k++) begin
        dv[k] <= dv[k-1];
      end
      v6 <= dv[Q_BITS];
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_x   <= mag_x_next;
      mag_y   <= mag_y_next;
      off_x   <= OFF_BITS'(mag_x) * OFF_BITS'(scale);
      off_y   <= OFF_BITS'(mag_y) * OFF_BITS'(scale);
      term_x  <= term_x_next;
      term_y  <= term_y_next;
      sum     <= SB'(term_x) + SB'(term_y) + SB'(inv_level);
      drem[0] <= SB'(num >> Q_BITS);
      dnq[0]  <= num[Q_BITS-1:0];
      dsum[0] <= sum;
      dz[0]   <= (sum == '0);
      for (int k = 1; k <= Q_BITS; k++) begin
        drem[k] <= nrem[k];
        dnq[k]  <= {dnq[k-1][Q_BITS-2:0], ge[k]};
        dsum[k] <= dsum[k-1];
        dz[k]   <= dz[k-1];
      end
      // zero sum: factor takes its maximum
      r       <= dz[Q_BITS] ? plf_pkg::R_LIMIT : RB'(dnq[Q_BITS]);
      p_red   <= PROD_BITS'(red) * PROD_BITS'(r) + HALF_P;
      p_green <= PROD_BITS'(green) * PROD_BITS'(r) + HALF_P;
      p_blue  <= PROD_BITS'(blue) * PROD_BITS'(r) + HALF_P;
      p_alpha <= (RB+1)'(r) + HALF_R;
      pix     <= pix_next;
    end
  end

  // output register and skid
  plf_pkg::pix_t out_pix;
  plf_pkg::pix_t skid_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= v8;
      end
    end else if (v8) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_pix <= skid_valid ? skid_pix : pix;
    end else if (adv && v8) begin
      skid_pix <= pix;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pix;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready && adv && v8) |=> skid_valid)
    else $error("finished word dropped while the output stalled");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> (skid_valid && $stable(skid_pix)))
    else $error("skid word lost while the output stalled");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (dv[Q_BITS] && !dz[Q_BITS]) |-> (drem[Q_BITS] < dsum[Q_BITS]))
    else $error("divider remainder not below the divisor");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_point_light_falloff_pixel.sv
module tb_point_light_falloff_pixel;

  localparam int FRAC       = plf_pkg::RECIP_FRAC_BITS_DEF;
  localparam int PIPE_DEPTH = 33 + plf_pkg::RECIP_FRAC_BITS_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int PHASES     = 20;
  localparam int PHASE_PIX  = 95;
  localparam int QUIET_FROM = PHASES - 3;

  localparam longint unsigned TERM_CAP = 64'h1 << 48;
  localparam longint unsigned OFF_CAP  = 64'h1 << 32;

  // index past the register file, the block drops writes to it
  localparam logic [plf_pkg::CFG_IDX_BITS-1:0] REG_NONE = 3'd7;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [plf_pkg::CFG_IDX_BITS-1:0] idx;
    logic [31:0]                      data;
    logic [11:0]                      col;
    logic [11:0]                      row;
    logic                             typed;
    plf_pkg::pix_t                    want;
  } dir_row_t;

  typedef struct {
    logic [plf_pkg::LIGHT_BITS-1:0] light_x;
    logic [plf_pkg::LIGHT_BITS-1:0] light_y;
    logic [plf_pkg::SCALE_BITS-1:0] scale;
    logic [plf_pkg::INV_BITS-1:0]   inv;
    logic [plf_pkg::CHAN_BITS-1:0]  red;
    logic [plf_pkg::CHAN_BITS-1:0]  green;
    logic [plf_pkg::CHAN_BITS-1:0]  blue;
  } light_cfg_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  // col, row
  logic [23:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  // alpha_out, blue_out, green_out, red_out
  logic [31:0] m_tdata;
  logic        cfg_we    = 1'b0;
  logic [plf_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [plf_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

  light_cfg_t    light_state;
  plf_pkg::pix_t pending_pixels [$];
  dir_row_t      dir_tab [30];
  int            mismatches = 0;
  int            cycles     = 0;
  int            stall_pct  = 20;
  int            gap_pct    = 0;
  int            stall_left = 0;

  point_light_falloff_pixel u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (int'($urandom_range(99)) < stall_pct) begin
      stall_left <= $urandom_range(13, 0);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // squared offset along one axis, Q.24, saturating for far pixels
  function automatic longint unsigned axis_square(logic [plf_pkg::LIGHT_BITS-1:0] light,
                                                  logic [11:0] coord,
                                                  logic [plf_pkg::SCALE_BITS-1:0] scl);
    longint d;
    longint unsigned mag, off, sq;
    d = longint'($signed(light)) - longint'({coord, 4'b0000});
    mag = (d < 0) ? unsigned'(-d) : unsigned'(d);
    off = mag * 64'(scl);
    if (off >= OFF_CAP) return TERM_CAP;
    sq = (off * off) >> 16;
    return (sq < TERM_CAP) ? sq : TERM_CAP;
  endfunction

  function automatic logic [7:0] tint(logic [7:0] c, longint unsigned r);
    longint unsigned v;
    v = (64'(c) * r + (64'h1 << (FRAC - 1))) >> FRAC;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic plf_pkg::pix_t falloff_pixel(logic [11:0] c, logic [11:0] r);
    longint unsigned sum, fall, whole;
    plf_pkg::pix_t p;
    sum = axis_square(light_state.light_x, c, light_state.scale)
        + axis_square(light_state.light_y, r, light_state.scale)
        + 64'(light_state.inv);
    if (sum == 0) fall = TERM_CAP;
    else fall = ((64'h1 << (24 + FRAC)) + (sum >> 1)) / sum;
    whole = (fall + (64'h1 << (FRAC - 1))) >> FRAC;
    p.alpha = (whole >= 255) ? 8'd0 : 8'(255 - whole);
    p.blue  = tint(light_state.blue, fall);
    p.green = tint(light_state.green, fall);
    p.red   = tint(light_state.red, fall);
    return p;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_pixels
    plf_pkg::pix_t got;
    plf_pkg::pix_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = plf_pkg::pix_t'(m_tdata);
      if (pending_pixels.size() == 0) begin
        $error("pixel word with nothing outstanding: %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("alpha_out", want.alpha, got.alpha);
        check_field("blue_out", want.blue, got.blue);
        check_field("green_out", want.green, got.green);
        check_field("red_out", want.red, got.red);
      end
    end
  end

  task automatic write_light_reg(input logic [plf_pkg::CFG_IDX_BITS-1:0] idx,
                                 input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      plf_pkg::REG_LIGHT_X:   light_state.light_x = val[plf_pkg::LIGHT_BITS-1:0];
      plf_pkg::REG_LIGHT_Y:   light_state.light_y = val[plf_pkg::LIGHT_BITS-1:0];
      plf_pkg::REG_SCALE:     light_state.scale   = val[plf_pkg::SCALE_BITS-1:0];
      plf_pkg::REG_INV_LEVEL: light_state.inv     = val;
      plf_pkg::REG_RED:       light_state.red     = val[7:0];
      plf_pkg::REG_GREEN:     light_state.green   = val[7:0];
      plf_pkg::REG_BLUE:      light_state.blue    = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [11:0] c, input logic [11:0] r,
                            input logic typed, input plf_pkg::pix_t want);
    s_tdata  <= {r, c};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_pixels.push_back(typed ? want : falloff_pixel(c, r));
  endtask

  // stop sending and wait for every outstanding pixel
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_reg_value(logic [plf_pkg::CFG_IDX_BITS-1:0] idx);
    int sel;
    sel = $urandom_range(7);
    case (idx)
      plf_pkg::REG_LIGHT_X, plf_pkg::REG_LIGHT_Y: begin
        if (sel == 0) return 32'h1_0000;
        if (sel == 1) return 32'h0_FFFF;
        if (sel < 4) return {15'd0, 17'($urandom)};
        return $urandom_range(65520);
      end
      plf_pkg::REG_SCALE: begin
        if (sel == 0) return 32'd0;
        if (sel == 1) return 32'h00FF_FFFF;
        return $urandom >> $urandom_range(20, 8);
      end
      plf_pkg::REG_INV_LEVEL: begin
        if (sel == 0) return 32'd0;
        if (sel == 1) return 32'hFFFF_FFFF;
        return $urandom >> $urandom_range(31, 0);
      end
      default: begin
        if (sel == 0) return 32'd0;
        if (sel == 1) return 32'd255;
        return $urandom;
      end
    endcase
  endfunction

  // half the pixels land near the light, where the falloff is not flat
  function automatic logic [11:0] pick_coord(logic [plf_pkg::LIGHT_BITS-1:0] light);
    int base;
    if ($urandom_range(1) == 1) return 12'($urandom);
    base = int'($signed(light)) >>> 4;
    return 12'(base + int'($urandom_range(32)) - 16);
  endfunction

  initial begin : stimulus
    int n;
    light_state = '{plf_pkg::LIGHT_RST, plf_pkg::LIGHT_RST, plf_pkg::SCALE_RST,
                    plf_pkg::INV_RST, plf_pkg::CHAN_RST, plf_pkg::CHAN_RST,
                    plf_pkg::CHAN_RST};
    dir_tab = '{
      '{ROW_PIX, '0, '0, 12'd0, 12'd0, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd254}},
      '{ROW_PIX, '0, '0, 12'd4095, 12'd4095, 1'b0, '0},
      '{ROW_PIX, '0, '0, 12'd1, 12'd0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_INV_LEVEL, 32'd0, '0, '0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_RED, 32'd0, '0, '0, 1'b0, '0},
      // light on the pixel with no intensity term: falloff at its ceiling
      '{ROW_PIX, '0, '0, 12'd0, 12'd0, 1'b1, '{8'd0, 8'd255, 8'd255, 8'd0}},
      '{ROW_CFG, plf_pkg::REG_SCALE, 32'h00FF_FFFF, '0, '0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_LIGHT_X, 32'h1_0000, '0, '0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_LIGHT_Y, 32'h1_0000, '0, '0, 1'b0, '0},
      // both square terms saturate, nothing of the light reaches here
      '{ROW_PIX, '0, '0, 12'd4095, 12'd4095, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}},
      '{ROW_CFG, plf_pkg::REG_LIGHT_X, 32'h0_FFFF, '0, '0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_LIGHT_Y, 32'h0_FFFF, '0, '0, 1'b0, '0},
      '{ROW_PIX, '0, '0, 12'd4095, 12'd4095, 1'b0, '0},
      '{ROW_PIX, '0, '0, 12'd0, 12'd0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_INV_LEVEL, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_GREEN, 32'd0, '0, '0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_BLUE, 32'd128, '0, '0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_SCALE, 32'd0, '0, '0, 1'b0, '0},
      '{ROW_PIX, '0, '0, 12'd2048, 12'd1, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_RED, 32'd255, '0, '0, 1'b0, '0},
      '{ROW_CFG, REG_NONE, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
      '{ROW_PIX, '0, '0, 12'd4095, 12'd0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_INV_LEVEL, 32'd1, '0, '0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_LIGHT_X, 32'd0, '0, '0, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_LIGHT_Y, 32'd0, '0, '0, 1'b0, '0},
      // very bright: every nonzero coloured channel clamps, alpha clamps at zero
      '{ROW_PIX, '0, '0, 12'd0, 12'd0, 1'b1, '{8'd255, 8'd0, 8'd255, 8'd0}},
      '{ROW_PIX, '0, '0, 12'd2, 12'd3, 1'b0, '0},
      '{ROW_CFG, plf_pkg::REG_SCALE, 32'h0001_0000, '0, '0, 1'b0, '0},
      '{ROW_PIX, '0, '0, 12'd3, 12'd4, 1'b0, '0},
      '{ROW_PIX, '0, '0, 12'd4095, 12'd4095, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        settle();
        write_light_reg(dir_tab[k].idx, dir_tab[k].data);
      end else begin
        cfg_we <= 1'b0;
        send_pixel(dir_tab[k].col, dir_tab[k].row, dir_tab[k].typed, dir_tab[k].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case ($urandom_range(3))
        0: gap_pct = 0;
        1: gap_pct = 8;
        2: gap_pct = 25;
        default: gap_pct = 60;
      endcase
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 8;
        2: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      if (ph >= QUIET_FROM) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      for (int i = 0; i <= int'(REG_NONE); i++)
        if ($urandom_range(9) < 7) write_light_reg(i[2:0], pick_reg_value(i[2:0]));
      cfg_we <= 1'b0;
      for (int k = 0; k < PHASE_PIX; k++) begin
        if (int'($urandom_range(99)) < gap_pct) begin
          s_tvalid <= 1'b0;
          n = $urandom_range(14, 1);
          repeat (n) @(posedge clk);
        end
        send_pixel(pick_coord(light_state.light_x), pick_coord(light_state.light_y), 1'b0, '0);
      end
    end

    settle();
    repeat (PIPE_DEPTH + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
